@@ src/oat_pkg.sv @@
// Shared types and constants for the one-at-a-time hash bucket indexer.
package oat_pkg;

  localparam int unsigned OAT_HASH_W   = 32;
  localparam int unsigned OAT_BYTE_W   = 8;
  localparam int unsigned OAT_TSIZE_W  = 17;
  localparam int unsigned OAT_IDX_W    = 16;
  localparam int unsigned OAT_QDEPTH   = 4;
  localparam int unsigned OAT_QAW      = $clog2(OAT_QDEPTH);
  localparam int unsigned OAT_QCW      = $clog2(OAT_QDEPTH + 1);
  localparam int unsigned OAT_DIVCNT_W = $clog2(OAT_HASH_W);

  localparam logic [OAT_TSIZE_W-1:0] OAT_TSIZE_RST = 17'd1024;
  localparam logic [OAT_TSIZE_W-1:0] OAT_MAX_BKT   = 17'd65536;

  localparam int unsigned OAT_ABS_SHL = 10;
  localparam int unsigned OAT_ABS_SHR = 6;
  localparam int unsigned OAT_FIN_SHL1 = 3;
  localparam int unsigned OAT_FIN_SHR = 11;
  localparam int unsigned OAT_FIN_SHL2 = 15;

  typedef logic [OAT_HASH_W-1:0] oat_hash_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } oat_qstat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MIX1,
    S_MIX2,
    S_MIX3,
    S_DIV,
    S_LOAD
  } oat_state_t;

endpackage

@@ src/oat_front.sv @@
// Front end: absorbs key bytes into the running hash, pushes finished keys.
module oat_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] key_byte
  input  logic               in_tlast,   // last_byte
  input  oat_pkg::oat_qstat_t q_stat,
  output logic               q_push,
  output oat_pkg::oat_hash_t q_wdata
);
  import oat_pkg::*;

  oat_hash_t hash_r;
  oat_hash_t hash_nxt;
  oat_hash_t h_add;
  oat_hash_t h_mix;
  logic      accept;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    h_add = hash_r + {{(OAT_HASH_W-OAT_BYTE_W){1'b0}}, in_tdata};
    h_mix = h_add + (h_add << OAT_ABS_SHL);
    hash_nxt = h_mix ^ (h_mix >> OAT_ABS_SHR);
  end

  assign q_push  = accept && in_tlast;
  assign q_wdata = hash_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= '0;
    end else if (accept) begin
      hash_r <= in_tlast ? '0 : hash_nxt;
    end
  end

endmodule

@@ src/oat_queue.sv @@
// Small queue of absorbed key hashes between front and back.
module oat_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  oat_pkg::oat_hash_t wdata,
  input  logic               pop,
  output oat_pkg::oat_hash_t rdata,
  output oat_pkg::oat_qstat_t stat
);
  import oat_pkg::*;

  oat_hash_t              mem_r [OAT_QDEPTH];
  logic [OAT_QAW-1:0]     wr_ptr_r;
  logic [OAT_QAW-1:0]     rd_ptr_r;
  logic [OAT_QCW-1:0]     count_r;

  assign stat.full  = (count_r == OAT_QCW'(OAT_QDEPTH));
  assign stat.empty = (count_r == '0);
  assign rdata      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty))
    else $error("queue pop while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not advance on push");
`endif

endmodule

@@ src/oat_back.sv @@
// Back end: final mix, bit-serial modulo by table size, output register.
module oat_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [16:0]         cfg_wr_data,
  input  oat_pkg::oat_qstat_t q_stat,
  input  oat_pkg::oat_hash_t  q_rdata,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [47:0]         out_tdata   // [31:0] hash_value, [47:32] bucket_index
);
  import oat_pkg::*;

  oat_state_t                state_r;
  oat_state_t                state_nxt;
  logic [OAT_TSIZE_W-1:0]    tsize_r;
  logic [OAT_TSIZE_W-1:0]    n_r;
  oat_hash_t                 h_r;
  oat_hash_t                 div_r;
  logic [OAT_IDX_W-1:0]      rem_r;
  logic [OAT_DIVCNT_W-1:0]   cnt_r;
  logic                      out_valid_r;
  oat_hash_t                 out_hash_r;
  logic [OAT_IDX_W-1:0]      out_idx_r;

  logic                      out_free;
  logic                      load_out;
  logic [OAT_TSIZE_W-1:0]    rem_sh;
  logic [OAT_TSIZE_W-1:0]    rem_sub;
  oat_hash_t                 mix3;

  assign out_free = !out_valid_r || out_tready;
  assign rem_sh   = {rem_r, div_r[OAT_HASH_W-1]};
  assign rem_sub  = (rem_sh >= n_r) ? (rem_sh - n_r) : rem_sh;
  assign mix3     = h_r + (h_r << OAT_FIN_SHL2);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!q_stat.empty) state_nxt = S_MIX1;
      S_MIX1: state_nxt = S_MIX2;
      S_MIX2: state_nxt = S_MIX3;
      S_MIX3: state_nxt = S_DIV;
      S_DIV:  if (cnt_r == '0) state_nxt = S_LOAD;
      S_LOAD: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      S_IDLE:  q_pop = !q_stat.empty;
      S_LOAD:  load_out = out_free;
      default: begin
        q_pop    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tsize_r     <= OAT_TSIZE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) tsize_r <= cfg_wr_data;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        h_r <= q_rdata;
        n_r <= (tsize_r > OAT_MAX_BKT) ? OAT_MAX_BKT : tsize_r;
      end
      S_MIX1: h_r <= h_r + (h_r << OAT_FIN_SHL1);
      S_MIX2: h_r <= h_r ^ (h_r >> OAT_FIN_SHR);
      S_MIX3: begin
        h_r   <= mix3;
        div_r <= mix3;
        rem_r <= '0;
        cnt_r <= OAT_DIVCNT_W'(OAT_HASH_W - 1);
      end
      S_DIV: begin
        rem_r <= rem_sub[OAT_IDX_W-1:0];
        div_r <= div_r << 1;
        cnt_r <= cnt_r - 1'b1;
      end
      S_LOAD: begin
        if (load_out) begin
          out_hash_r <= h_r;
          // zero buckets gives index zero
          out_idx_r  <= (n_r == '0) ? '0 : rem_r;
        end
      end
      default: h_r <= h_r;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_idx_r, out_hash_r};

`ifndef ASSERT_OFF
  a_pop_starts_key: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_MIX1))
    else $error("pop did not start a key");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MIX3) |=> (cnt_r == OAT_DIVCNT_W'(OAT_HASH_W - 1)))
    else $error("divide count not loaded");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD && n_r != '0) |-> ({1'b0, rem_r} < n_r))
    else $error("remainder not below table size");
`endif

endmodule

@@ src/oat_hash_bucket_index.sv @@
// Top level of the one-at-a-time hash bucket indexer.
//
//  port group | dir | payload (low bit up)                      | role
//  in_        | in  | tdata: key_byte[7:0]; tlast: last_byte     | key bytes
//  out_       | out | tdata: hash_value[31:0], bucket_index[47:32]| one beat per key
//  cfg_       | in  | wr_data: table_size[16:0]                  | bucket count
//
// Key bytes are taken at one per cycle while the 4-entry key queue has room.
// Each key then goes through the back end alone: a pop, 3 final-mix steps, a
// remainder at one bit per cycle, an output load; that divider sets the
// sustained key rate. table_size resets to 1024; all control resets with
// rst_n (sync, active low). out_ stalls hold the result register and back
// up into the queue, which then drops in_tready.
module oat_hash_bucket_index (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] key_byte
  input  logic        in_tlast,    // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [31:0] hash_value, [47:32] bucket_index
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data  // table_size
);
  import oat_pkg::*;

  oat_qstat_t q_stat;
  logic       q_push;
  logic       q_pop;
  oat_hash_t  q_wdata;
  oat_hash_t  q_rdata;

  oat_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  oat_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  oat_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_stat      (q_stat),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking stream testbench for the one-at-a-time hash bucket indexer.
module tb;
  import oat_pkg::*;

  typedef struct packed {
    logic [OAT_BYTE_W-1:0] key_byte;
    logic                  last_byte;
  } key_beat_t;

  typedef struct packed {
    oat_hash_t             hash_value;
    logic [OAT_IDX_W-1:0]  bucket_index;
  } bucket_result_t;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned DRAIN_CYCLES  = 60;
  localparam int unsigned PHASE_BEATS   = 85;
  localparam int unsigned NUM_PHASES    = 12;
  localparam int unsigned MAX_REPORTS   = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;      // [7:0] key_byte
  logic        in_tlast = 1'b0;    // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;          // [31:0] hash_value, [47:32] bucket_index
  logic        cfg_wr_en = 1'b0;
  logic [16:0] cfg_wr_data = '0;   // table_size

  key_beat_t              pending_beats[$];
  bucket_result_t         expected_buckets[$];
  oat_hash_t              running_hash = '0;
  logic [OAT_TSIZE_W-1:0] bucket_count = OAT_TSIZE_RST;
  int unsigned            send_idle_pct = 0;
  int unsigned            recv_stall_pct = 0;
  int unsigned            hold_reqs = 0;
  int unsigned            hold_seen = 0;
  int unsigned            hold_left = 0;
  int unsigned            mismatches = 0;
  int unsigned            cycles = 0;

  oat_hash_bucket_index u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** oat_hash_bucket_index: FAILED **");
      $finish;
    end
  end

  // Key byte driver; also folds each accepted beat into the expected hash.
  always @(posedge clk) begin : drive_keys
    oat_hash_t              h;
    logic [OAT_TSIZE_W-1:0] n;
    logic [OAT_IDX_W-1:0]   idx;
    key_beat_t              nxt;
    if (!rst_n) begin
      in_tvalid    <= 1'b0;
      running_hash <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        h = running_hash + oat_hash_t'(in_tdata);
        h = h + (h << OAT_ABS_SHL);
        h = h ^ (h >> OAT_ABS_SHR);
        if (in_tlast) begin
          h = h + (h << OAT_FIN_SHL1);
          h = h ^ (h >> OAT_FIN_SHR);
          h = h + (h << OAT_FIN_SHL2);
          // register saturates at the max bucket count; zero buckets gives index 0
          n = (bucket_count > OAT_MAX_BKT) ? OAT_MAX_BKT : bucket_count;
          idx = (n == '0) ? '0 : OAT_IDX_W'(h % n);
          expected_buckets.push_back('{h, idx});
          h = '0;
        end
        running_hash <= h;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.key_byte;
          in_tlast  <= nxt.last_byte;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started by the stimulus through hold_reqs.
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    bucket_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_buckets.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("unexpected result beat: hash_value %h bucket_index %0d",
                   out_tdata[31:0], out_tdata[47:32]);
        end
        mismatches++;
      end else begin
        want = expected_buckets.pop_front();
        if (out_tdata[31:0] !== want.hash_value ||
            out_tdata[47:32] !== want.bucket_index) begin
          if (mismatches < MAX_REPORTS) begin
            $display("mismatch: hash_value exp %h got %h, bucket_index exp %0d got %0d",
                     want.hash_value, out_tdata[31:0], want.bucket_index,
                     out_tdata[47:32]);
          end
          mismatches++;
        end
      end
    end
  end

  function automatic void push_beat(input logic [7:0] b, input logic last);
    key_beat_t kb;
    kb.key_byte  = b;
    kb.last_byte = last;
    pending_beats.push_back(kb);
  endfunction

  // Mostly short keys, a few long ones; returns the key length.
  function automatic int unsigned push_random_key();
    int unsigned r;
    int unsigned len;
    r = $urandom_range(99);
    if (r < 60) begin
      len = $urandom_range(1, 4);
    end else if (r < 90) begin
      len = $urandom_range(5, 12);
    end else begin
      len = $urandom_range(13, 32);
    end
    for (int unsigned i = 0; i < len; i++) begin
      push_beat(8'($urandom_range(255)), i == len - 1);
    end
    return len;
  endfunction

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_tvalid || expected_buckets.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin : stimulus
    logic [OAT_TSIZE_W-1:0] sizes[NUM_PHASES];
    int unsigned            beats;
    sizes = '{17'd1, 17'd65536, 17'd0, 17'h1FFFF, 17'd65535, 17'd1000,
              17'd65537, 17'd3, 17'h0AAAA, 17'h15555, 17'd0, 17'd0};
    sizes[10] = OAT_TSIZE_W'($urandom_range(1, 65536));
    sizes[11] = OAT_TSIZE_W'($urandom_range(2, 300));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed keys under the reset table size: single-byte keys at both
    // extremes, a short text key, alternating bit patterns, a longer key
    push_beat(8'h00, 1'b1);
    push_beat(8'hFF, 1'b1);
    push_beat(8'h61, 1'b0);
    push_beat(8'h62, 1'b0);
    push_beat(8'h63, 1'b1);
    push_beat(8'hAA, 1'b0);
    push_beat(8'h55, 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b1);
    for (int unsigned i = 0; i < 12; i++) begin
      push_beat(8'(i * 23), i == 11);
    end

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= sizes[p];
      @(posedge clk);
      cfg_wr_en   <= 1'b0;
      @(negedge clk);
      bucket_count = sizes[p];
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 77;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 77;
        end
        default: begin
          send_idle_pct  = 18;
          recv_stall_pct = 18;
        end
      endcase
      // back-pressure: sink holds off while the source streams at full rate
      if (p == 4 || p == 8) begin
        hold_reqs++;
      end
      beats = 0;
      while (beats < PHASE_BEATS) begin
        beats += push_random_key();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += expected_buckets.size();
    if (mismatches == 0) begin
      $display("** oat_hash_bucket_index: PASSED **");
    end else begin
      $display("** oat_hash_bucket_index: FAILED **");
    end
    $finish;
  end

endmodule
